[rtl/yrc_pkg.sv]
`default_nettype none
package yrc_pkg;

  // Default row length of the even-row store
  localparam int MAX_ROW_SAMPLES_DEF = 2048;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Q10 fixed point
  localparam int Q_BITS = 10;
  localparam int Q_HALF = 512;
  localparam int GAIN_Y_UP   = 1192;
  localparam int GAIN_Y_DOWN = 879;
  localparam int GAIN_C_UP   = 1161;
  localparam int GAIN_C_DOWN = 903;

  // Width of the pre-shift sum and of the shifted result
  localparam int SUM_W = 21;
  localparam int RES_W = SUM_W - Q_BITS;

  // Configuration register indexes
  localparam logic [1:0] REG_DIRECTION = 2'd0;
  localparam logic [1:0] REG_COMPONENT = 2'd1;
  localparam logic [1:0] REG_VMODE     = 2'd2;

  // Vertical modes
  localparam logic [1:0] MODE_ONE = 2'd0;
  localparam logic [1:0] MODE_DUP = 2'd1;
  localparam logic [1:0] MODE_AVG = 2'd2;

  // Direction and component codes
  localparam logic DIR_TO_FULL    = 1'b0;
  localparam logic DIR_TO_LIMITED = 1'b1;
  localparam logic COMP_LUMA      = 1'b0;
  localparam logic COMP_CHROMA    = 1'b1;

  // How the front classified an accepted word
  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_DUP,
    KIND_AVG
  } kind_t;

  // Queue entry handed from front to back
  typedef struct packed {
    logic [7:0] value;
    logic       dup;
  } entry_t;

  // Gain for the current plane and direction
  function automatic logic [10:0] gain_sel(input logic component, input logic direction);
    logic [10:0] g;
    if (component == COMP_LUMA) begin
      g = (direction == DIR_TO_FULL) ? 11'(GAIN_Y_UP) : 11'(GAIN_Y_DOWN);
    end else begin
      g = (direction == DIR_TO_FULL) ? 11'(GAIN_C_UP) : 11'(GAIN_C_DOWN);
    end
    return g;
  endfunction

  // Additive term: rounding half plus offset
  function automatic logic signed [SUM_W-1:0] offset_sel(input logic component,
                                                        input logic direction);
    logic signed [SUM_W-1:0] o;
    if (component == COMP_LUMA) begin
      if (direction == DIR_TO_FULL) begin
        o = SUM_W'(Q_HALF - 16 * GAIN_Y_UP);
      end else begin
        o = SUM_W'(Q_HALF + (16 << Q_BITS));
      end
    end else begin
      o = SUM_W'(Q_HALF + (128 << Q_BITS));
    end
    return o;
  endfunction

  // Lower clamp bound
  function automatic logic signed [RES_W-1:0] clamp_lo(input logic direction);
    return (direction == DIR_TO_FULL) ? RES_W'(0) : RES_W'(16);
  endfunction

  // Upper clamp bound
  function automatic logic signed [RES_W-1:0] clamp_hi(input logic component,
                                                      input logic direction);
    logic signed [RES_W-1:0] h;
    if (direction == DIR_TO_FULL) begin
      h = RES_W'(255);
    end else if (component == COMP_LUMA) begin
      h = RES_W'(235);
    end else begin
      h = RES_W'(240);
    end
    return h;
  endfunction

endpackage
`default_nettype wire

[rtl/yrc_front.sv]
`default_nettype none
module yrc_front #(
  parameter int MAX_ROW_SAMPLES = yrc_pkg::MAX_ROW_SAMPLES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [7:0]       sample,
  input  wire logic             end_of_row,
  input  wire logic             plane_start,
  input  wire logic [1:0]       vertical_mode,
  output logic                  push,
  output yrc_pkg::entry_t       push_entry,
  input  wire logic             full
);

  localparam int ColW = $clog2(MAX_ROW_SAMPLES);

  logic                  accept;
  logic [ColW-1:0]       column;
  logic [ColW-1:0]       column_next;
  logic [ColW-1:0]       col_cur;
  logic                  odd_row;
  logic                  odd_row_next;
  logic                  odd_cur;
  logic                  wr_en;
  logic                  rd_en;
  logic                  keep;
  yrc_pkg::kind_t        kind;
  logic [7:0]            row_store [MAX_ROW_SAMPLES];
  logic [7:0]            rd_data;
  logic                  s1_valid;
  logic [7:0]            s1_sample;
  yrc_pkg::kind_t        s1_kind;
  logic [8:0]            pair_sum;

  // Take a word whenever the holding stage is empty or drains this cycle
  assign s_tready = !s1_valid || !full;
  assign accept   = s_tvalid && s_tready;
  assign push     = s1_valid && !full;

  // Plane start restarts column and row parity before use
  assign col_cur = plane_start ? '0 : column;
  assign odd_cur = plane_start ? 1'b0 : odd_row;

  // Classify the word
  always_comb begin
    kind  = yrc_pkg::KIND_PASS;
    keep  = 1'b1;
    wr_en = 1'b0;
    rd_en = 1'b0;
    unique case (vertical_mode)
      yrc_pkg::MODE_DUP: begin
        kind = yrc_pkg::KIND_DUP;
      end
      yrc_pkg::MODE_AVG: begin
        if (odd_cur) begin
          kind  = yrc_pkg::KIND_AVG;
          rd_en = 1'b1;
        end else begin
          keep  = 1'b0;
          wr_en = 1'b1;
        end
      end
      default: begin
        kind = yrc_pkg::KIND_PASS;
      end
    endcase
  end

  // Advance column (saturating) and row parity
  always_comb begin
    odd_row_next = odd_cur;
    if (end_of_row) begin
      column_next  = '0;
      odd_row_next = !odd_cur;
    end else if (col_cur < ColW'(MAX_ROW_SAMPLES - 1)) begin
      column_next = col_cur + 1'b1;
    end else begin
      column_next = col_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column  <= '0;
      odd_row <= 1'b0;
    end else if (accept) begin
      column  <= column_next;
      odd_row <= odd_row_next;
    end
  end

  // Even-row store: write on even rows, registered read on odd rows
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      row_store[col_cur] <= sample;
    end
    if (accept && rd_en) begin
      rd_data <= row_store[col_cur];
    end
  end

  // Holding stage in front of the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && keep) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      s1_sample <= sample;
      s1_kind   <= kind;
    end
  end

  // Mean of the stored and current sample for averaged rows
  assign pair_sum         = {1'b0, rd_data} + {1'b0, s1_sample};
  assign push_entry.value = (s1_kind == yrc_pkg::KIND_AVG) ? pair_sum[8:1] : s1_sample;
  assign push_entry.dup   = (s1_kind == yrc_pkg::KIND_DUP);

endmodule
`default_nettype wire

[rtl/yrc_fifo.sv]
`default_nettype none
module yrc_fifo #(
  parameter int DEPTH = yrc_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire yrc_pkg::entry_t  push_entry,
  output logic                  full,
  input  wire logic             pop,
  output yrc_pkg::entry_t       pop_entry,
  output logic                  empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  yrc_pkg::entry_t  slots [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign full      = (count == CntW'(DEPTH));
  assign empty     = (count == '0);
  assign pop_entry = slots[rd_ptr];

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
`endif

endmodule
`default_nettype wire

[rtl/yrc_back.sv]
`default_nettype none
module yrc_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             direction,
  input  wire logic             component,
  input  wire logic             empty,
  input  wire yrc_pkg::entry_t  pop_entry,
  output logic                  pop,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [7:0]            pixel_out,
  output logic                  row_copy,
  output logic                  last_of_run
);

  localparam int SumW = yrc_pkg::SUM_W;
  localparam int ResW = yrc_pkg::RES_W;

  logic signed [8:0]       xs;
  logic signed [SumW-1:0]  prod;
  logic                    p_valid;
  logic signed [SumW-1:0]  p_sum;
  logic                    p_dup;
  logic                    p_phase;
  logic                    out_load;
  logic                    p_done;
  logic signed [ResW-1:0]  shifted;
  logic signed [ResW-1:0]  lo;
  logic signed [ResW-1:0]  hi;
  logic signed [ResW-1:0]  clamped;

  // Handshake between product stage and output register
  assign out_load = p_valid && (!m_tvalid || m_tready);
  assign p_done   = out_load && (!p_dup || p_phase);
  assign pop      = !empty && (!p_valid || p_done);

  // Center chroma, then scale by the Q10 gain
  always_comb begin
    xs = $signed({1'b0, pop_entry.value});
    if (component == yrc_pkg::COMP_CHROMA) begin
      xs = xs - 9'sd128;
    end
  end

  assign prod = xs * $signed({1'b0, yrc_pkg::gain_sel(component, direction)});

  // Product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      p_phase <= 1'b0;
    end else begin
      if (pop) begin
        p_valid <= 1'b1;
        p_phase <= 1'b0;
      end else if (p_done) begin
        p_valid <= 1'b0;
        p_phase <= 1'b0;
      end else if (out_load) begin
        p_phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      p_sum <= prod + yrc_pkg::offset_sel(component, direction);
      p_dup <= pop_entry.dup;
    end
  end

  // Floor shift and clamp
  assign shifted = p_sum[SumW-1:yrc_pkg::Q_BITS];
  assign lo      = yrc_pkg::clamp_lo(direction);
  assign hi      = yrc_pkg::clamp_hi(component, direction);

  always_comb begin
    if (shifted < lo) begin
      clamped = lo;
    end else if (shifted > hi) begin
      clamped = hi;
    end else begin
      clamped = shifted;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pixel_out   <= clamped[7:0];
      row_copy    <= p_dup && p_phase;
      last_of_run <= !p_dup || p_phase;
    end
  end

`ifndef ASSERT_OFF
  a_second_copy_follows: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && m_tready && !last_of_run) |=> (m_tvalid && row_copy && last_of_run))
    else $error("second row copy did not follow the first");
  a_limited_floor: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && direction == yrc_pkg::DIR_TO_LIMITED) |-> (pixel_out >= 8'd16))
    else $error("limited range result below floor");
`endif

endmodule
`default_nettype wire

[rtl/yuv_range_and_chroma_row_converter_top.sv]
`default_nettype none
// Channel  Handshake           Payload
// s_       tvalid / tready     tdata = sample, tlast = end_of_row, tuser = plane_start
// m_       tvalid / tready     tdata = pixel_out, tlast = last_of_run, tuser = row_copy
// cfg_     we (no wait)        addr = register index, data = register value
//
// One sample per cycle in one-to-one and averaging modes while m_tready is held high;
// duplicate mode emits two words per sample on the single output port, so it sustains a lower sample rate.
// From input to output a sample passes the holding stage, queue, product and output registers.
// rst is synchronous; the even-row store is not cleared and needs no clearing pass.
// A four-entry queue lets the front keep accepting while the output stalls.
module yuv_range_and_chroma_row_converter_top #(
  parameter int MAX_ROW_SAMPLES = yrc_pkg::MAX_ROW_SAMPLES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] sample
  input  wire logic        s_tlast,
  input  wire logic        s_tuser,   // [0] plane_start
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] pixel_out
  output logic             m_tlast,
  output logic             m_tuser,   // [0] row_copy
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [1:0]  cfg_data
);

  logic             direction;
  logic             component;
  logic [1:0]       vertical_mode;
  logic             push;
  yrc_pkg::entry_t  push_entry;
  logic             full;
  logic             pop;
  yrc_pkg::entry_t  pop_entry;
  logic             empty;

  // Configuration registers; other indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      direction     <= 1'b0;
      component     <= 1'b0;
      vertical_mode <= yrc_pkg::MODE_ONE;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        yrc_pkg::REG_DIRECTION: direction     <= cfg_data[0];
        yrc_pkg::REG_COMPONENT: component     <= cfg_data[0];
        yrc_pkg::REG_VMODE:     vertical_mode <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  yrc_front #(
    .MAX_ROW_SAMPLES (MAX_ROW_SAMPLES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .sample        (s_tdata),
    .end_of_row    (s_tlast),
    .plane_start   (s_tuser),
    .vertical_mode (vertical_mode),
    .push          (push),
    .push_entry    (push_entry),
    .full          (full)
  );

  yrc_fifo #(
    .DEPTH (yrc_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (empty)
  );

  yrc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .direction   (direction),
    .component   (component),
    .empty       (empty),
    .pop_entry   (pop_entry),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .pixel_out   (m_tdata),
    .row_copy    (m_tuser),
    .last_of_run (m_tlast)
  );

endmodule
`default_nettype wire
